// File: src/plsf_pkg.sv
// Package for the least-squares plane fit: channel payload types, the controller
// and datapath interface structs, register-file addresses and the fit program.
// No dependencies.
package plsf_pkg;

	// Width of the exact fit arithmetic (two's complement).
	localparam int BIG_W = 256;
	localparam int IT_W = $clog2(BIG_W);

	// Register-file addresses of the fit datapath.
	localparam int RF_DEPTH = 32;
	localparam int RA_W = $clog2(RF_DEPTH);
	typedef logic [RA_W-1:0] raddr_t;

	localparam raddr_t R_N   = 5'd0;
	localparam raddr_t R_SX  = 5'd1;
	localparam raddr_t R_SY  = 5'd2;
	localparam raddr_t R_SZ  = 5'd3;
	localparam raddr_t R_SXX = 5'd4;
	localparam raddr_t R_SYY = 5'd5;
	localparam raddr_t R_SXY = 5'd6;
	localparam raddr_t R_SZX = 5'd7;
	localparam raddr_t R_SZY = 5'd8;
	localparam raddr_t R_K   = 5'd9;
	localparam raddr_t R_T1  = 5'd10;
	localparam raddr_t R_T2  = 5'd11;
	localparam raddr_t R_MXX = 5'd12;
	localparam raddr_t R_MYY = 5'd13;
	localparam raddr_t R_MXY = 5'd14;
	localparam raddr_t R_MZX = 5'd15;
	localparam raddr_t R_MZY = 5'd16;
	localparam raddr_t R_D   = 5'd17;
	localparam raddr_t R_NA  = 5'd18;
	localparam raddr_t R_NB  = 5'd19;
	localparam raddr_t R_MX  = 5'd20;
	localparam raddr_t R_MY  = 5'd21;
	localparam raddr_t R_MZ  = 5'd22;
	localparam raddr_t R_A   = 5'd23;
	localparam raddr_t R_B   = 5'd24;
	localparam raddr_t R_C   = 5'd25;

	// Scale of the slopes: 16 fraction bits.
	localparam logic [BIG_W-1:0] K_SCALE = BIG_W'(65536);

	// Fit status codes.
	localparam logic [1:0] FS_OK         = 2'd0;
	localparam logic [1:0] FS_DEGENERATE = 2'd1;
	localparam logic [1:0] FS_CAPACITY   = 2'd2;

	typedef struct packed {
		logic signed [23:0] coord_x;
		logic signed [23:0] coord_y;
		logic signed [23:0] coord_z;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic signed [31:0] slope_a;
		logic signed [31:0] slope_b;
		logic signed [31:0] offset_c;
		logic signed [23:0] mean_x;
		logic signed [23:0] mean_y;
		logic signed [23:0] mean_z;
		logic [1:0]         fit_status;
	} fit_t;

	typedef enum logic [1:0] {
		OP_LD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		op_t    op;
		raddr_t rd;
		raddr_t ra;
		raddr_t rb;
	} instr_t;

	typedef struct packed {
		logic   push;
		logic   rd_en;
		logic   start;
		logic   clear;
		op_t    op;
		raddr_t rd;
		raddr_t ra;
		raddr_t rb;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic done;
	} dp_status_t;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_DRAIN,
		ST_READ,
		ST_EXEC,
		ST_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MUL,
		PH_DPREP,
		PH_DIV,
		PH_DFIN
	} phase_t;

	localparam int PROG_LEN = 48;
	localparam int PC_W = $clog2(PROG_LEN);

	// Fit program: load the sums, form the centred moments, the denominator and
	// numerators, then the means, the slopes and the offset.
	localparam instr_t PROG [PROG_LEN] = '{
		'{OP_LD,  R_N,   R_N,   R_N},
		'{OP_LD,  R_SX,  R_N,   R_N},
		'{OP_LD,  R_SY,  R_N,   R_N},
		'{OP_LD,  R_SZ,  R_N,   R_N},
		'{OP_LD,  R_SXX, R_N,   R_N},
		'{OP_LD,  R_SYY, R_N,   R_N},
		'{OP_LD,  R_SXY, R_N,   R_N},
		'{OP_LD,  R_SZX, R_N,   R_N},
		'{OP_LD,  R_SZY, R_N,   R_N},
		'{OP_LD,  R_K,   R_N,   R_N},
		'{OP_MUL, R_T1,  R_N,   R_SXX},
		'{OP_MUL, R_T2,  R_SX,  R_SX},
		'{OP_SUB, R_MXX, R_T1,  R_T2},
		'{OP_MUL, R_T1,  R_N,   R_SYY},
		'{OP_MUL, R_T2,  R_SY,  R_SY},
		'{OP_SUB, R_MYY, R_T1,  R_T2},
		'{OP_MUL, R_T1,  R_N,   R_SXY},
		'{OP_MUL, R_T2,  R_SX,  R_SY},
		'{OP_SUB, R_MXY, R_T1,  R_T2},
		'{OP_MUL, R_T1,  R_N,   R_SZX},
		'{OP_MUL, R_T2,  R_SZ,  R_SX},
		'{OP_SUB, R_MZX, R_T1,  R_T2},
		'{OP_MUL, R_T1,  R_N,   R_SZY},
		'{OP_MUL, R_T2,  R_SZ,  R_SY},
		'{OP_SUB, R_MZY, R_T1,  R_T2},
		'{OP_MUL, R_T1,  R_MXX, R_MYY},
		'{OP_MUL, R_T2,  R_MXY, R_MXY},
		'{OP_SUB, R_D,   R_T1,  R_T2},
		'{OP_MUL, R_T1,  R_MZX, R_MYY},
		'{OP_MUL, R_T2,  R_MZY, R_MXY},
		'{OP_SUB, R_NA,  R_T1,  R_T2},
		'{OP_MUL, R_T1,  R_MXX, R_MZY},
		'{OP_MUL, R_T2,  R_MZX, R_MXY},
		'{OP_SUB, R_NB,  R_T1,  R_T2},
		'{OP_DIV, R_MX,  R_SX,  R_N},
		'{OP_DIV, R_MY,  R_SY,  R_N},
		'{OP_DIV, R_MZ,  R_SZ,  R_N},
		'{OP_MUL, R_T1,  R_NA,  R_K},
		'{OP_DIV, R_A,   R_T1,  R_D},
		'{OP_MUL, R_T1,  R_NB,  R_K},
		'{OP_DIV, R_B,   R_T1,  R_D},
		'{OP_MUL, R_T1,  R_SZ,  R_D},
		'{OP_MUL, R_T2,  R_NA,  R_SX},
		'{OP_SUB, R_T1,  R_T1,  R_T2},
		'{OP_MUL, R_T2,  R_NB,  R_SY},
		'{OP_SUB, R_T1,  R_T1,  R_T2},
		'{OP_MUL, R_T2,  R_N,   R_D},
		'{OP_DIV, R_C,   R_T1,  R_T2}
	};

	// Saturate a wide signed value to 32 bits.
	function automatic logic [31:0] sat32(input logic [BIG_W-1:0] v);
		logic fits;
		fits = (v[BIG_W-1:31] == '0) || (v[BIG_W-1:31] == '1);
		if (fits) begin
			return v[31:0];
		end else if (v[BIG_W-1]) begin
			return 32'h8000_0000;
		end else begin
			return 32'h7fff_ffff;
		end
	endfunction

	// Saturate a wide signed value to 24 bits.
	function automatic logic [23:0] sat24(input logic [BIG_W-1:0] v);
		logic fits;
		fits = (v[BIG_W-1:23] == '0) || (v[BIG_W-1:23] == '1);
		if (fits) begin
			return v[23:0];
		end else if (v[BIG_W-1]) begin
			return 24'h80_0000;
		end else begin
			return 24'h7f_ffff;
		end
	endfunction

endpackage

// File: src/plane_least_squares_fit.sv
// Top level of the streaming least-squares plane fit z = A*x + B*y + C.
// Depends on plsf_pkg, plsf_ctrl and plsf_dp.
//
//   channel   signals                        transfer moves
//   pt        pt_valid, pt_stall, pt         one point and its last flag
//   fit       fit_valid, fit_stall, fit      one fit result per point set
//
// Points are taken one per cycle while a set is being gathered; each passes a
// two-stage multiply pipeline and is added into exact moment sums.
// After the transfer of a point marked last, pt_stall stays high while the
// fit runs: a program of 48 steps on one shared shift-add multiplier and one
// restoring divider, each 256 bits wide and one bit per cycle. That is
// 22 multiplications, 6 divisions and 20 loads or subtractions, run after
// the point pipeline has drained.
// The result is held on fit until its transfer; the sums then clear and the
// next set may begin. Reset clears the sums and returns to gathering points.
module plane_least_squares_fit #(
	parameter int MAX_POINTS = 4096,
	parameter int COORD_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pt_valid,
	output logic             pt_stall,
	input  plsf_pkg::point_t pt,
	output logic             fit_valid,
	input  logic             fit_stall,
	output plsf_pkg::fit_t   fit
);

	// Command and status between the sequencer and the arithmetic.
	plsf_pkg::cmd_t       cmd;
	plsf_pkg::dp_status_t status;

	// The sequencer decides when points are taken, when each program step
	// starts, and when the finished result is offered.
	plsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (pt_valid),
		.pt_last   (pt.last_point),
		.pt_stall  (pt_stall),
		.status    (status),
		.cmd       (cmd),
		.fit_valid (fit_valid),
		.fit_stall (fit_stall)
	);

	// The datapath holds the sums, the register file and the wide units, and
	// keeps the result fields stable while the result waits.
	plsf_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pt     (pt),
		.status (status),
		.fit    (fit)
	);

endmodule

// File: src/plsf_dp.sv
// Datapath of the plane fit: point pipeline with moment accumulators, a register
// file, a shift-add multiplier and a restoring divider, and the result registers.
// Depends on plsf_pkg.
module plsf_dp #(
	parameter int MAX_POINTS = 4096,
	parameter int COORD_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  plsf_pkg::cmd_t      cmd,
	input  plsf_pkg::point_t    pt,
	output plsf_pkg::dp_status_t status,
	output plsf_pkg::fit_t      fit
);

	localparam int BW = plsf_pkg::BIG_W;
	localparam int LOG_N = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SUM1_W = COORD_BITS + LOG_N;
	localparam int SUM2_W = 2 * COORD_BITS + LOG_N;
	localparam int PROD_W = 2 * COORD_BITS;

	// Point pipeline.
	logic                          v_s1, v_s2;
	logic signed [COORD_BITS-1:0]  x_s1, y_s1, z_s1;
	logic signed [COORD_BITS-1:0]  x_s2, y_s2, z_s2;
	logic signed [PROD_W-1:0]      xx_s2, yy_s2, xy_s2, zx_s2, zy_s2;

	logic [CNT_W-1:0]              count_q;
	logic signed [SUM1_W-1:0]      sum_x_q, sum_y_q, sum_z_q;
	logic signed [SUM2_W-1:0]      sum_xx_q, sum_yy_q, sum_xy_q, sum_zx_q, sum_zy_q;
	logic                          cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.push;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			x_s1 <= COORD_BITS'($unsigned(pt.coord_x));
			y_s1 <= COORD_BITS'($unsigned(pt.coord_y));
			z_s1 <= COORD_BITS'($unsigned(pt.coord_z));
		end
		x_s2  <= x_s1;
		y_s2  <= y_s1;
		z_s2  <= z_s1;
		xx_s2 <= PROD_W'(x_s1) * PROD_W'(x_s1);
		yy_s2 <= PROD_W'(y_s1) * PROD_W'(y_s1);
		xy_s2 <= PROD_W'(x_s1) * PROD_W'(y_s1);
		zx_s2 <= PROD_W'(z_s1) * PROD_W'(x_s1);
		zy_s2 <= PROD_W'(z_s1) * PROD_W'(y_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_z_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			sum_zx_q <= '0;
			sum_zy_q <= '0;
			cap_q    <= 1'b0;
		end else if (cmd.clear) begin
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_z_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			sum_zx_q <= '0;
			sum_zy_q <= '0;
			cap_q    <= 1'b0;
		end else if (v_s2) begin
			if (count_q < CNT_W'(MAX_POINTS)) begin
				count_q  <= count_q + CNT_W'(1);
				sum_x_q  <= sum_x_q + SUM1_W'(x_s2);
				sum_y_q  <= sum_y_q + SUM1_W'(y_s2);
				sum_z_q  <= sum_z_q + SUM1_W'(z_s2);
				sum_xx_q <= sum_xx_q + SUM2_W'(xx_s2);
				sum_yy_q <= sum_yy_q + SUM2_W'(yy_s2);
				sum_xy_q <= sum_xy_q + SUM2_W'(xy_s2);
				sum_zx_q <= sum_zx_q + SUM2_W'(zx_s2);
				sum_zy_q <= sum_zy_q + SUM2_W'(zy_s2);
			end else begin
				cap_q <= 1'b1;
			end
		end
	end

	// Register file with registered reads.
	logic [BW-1:0]      rf_mem [plsf_pkg::RF_DEPTH];
	logic [BW-1:0]      rd_a_q, rd_b_q;
	logic               wr_en;
	plsf_pkg::raddr_t   wr_addr;
	logic [BW-1:0]      wr_data;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_a_q <= rf_mem[cmd.ra];
			rd_b_q <= rf_mem[cmd.rb];
		end
		if (wr_en) begin
			rf_mem[wr_addr] <= wr_data;
		end
	end

	// Arithmetic unit.
	plsf_pkg::phase_t   ph_q;
	plsf_pkg::raddr_t   rd_q;
	logic [BW-1:0]      x_q, y_q, acc_q, quo_q;
	logic [plsf_pkg::IT_W-1:0] it_q;
	logic               neg_q, done_q;

	logic [BW-1:0]      ld_val, sub_val, mul_next, rem_sh, rem_next, quo_fin;
	logic [BW-1:0]      abs_a, abs_b;
	logic               rem_ge;

	always_comb begin
		case (cmd.rd)
			plsf_pkg::R_N:   ld_val = BW'(count_q);
			plsf_pkg::R_SX:  ld_val = BW'(sum_x_q);
			plsf_pkg::R_SY:  ld_val = BW'(sum_y_q);
			plsf_pkg::R_SZ:  ld_val = BW'(sum_z_q);
			plsf_pkg::R_SXX: ld_val = BW'(sum_xx_q);
			plsf_pkg::R_SYY: ld_val = BW'(sum_yy_q);
			plsf_pkg::R_SXY: ld_val = BW'(sum_xy_q);
			plsf_pkg::R_SZX: ld_val = BW'(sum_zx_q);
			plsf_pkg::R_SZY: ld_val = BW'(sum_zy_q);
			plsf_pkg::R_K:   ld_val = plsf_pkg::K_SCALE;
			default:         ld_val = '0;
		endcase
	end

	assign sub_val  = rd_a_q - rd_b_q;
	assign mul_next = y_q[0] ? acc_q + x_q : acc_q;
	assign rem_sh   = {acc_q[BW-2:0], x_q[BW-1]};
	assign rem_ge   = rem_sh >= y_q;
	assign rem_next = rem_ge ? rem_sh - y_q : rem_sh;
	assign quo_fin  = neg_q ? -quo_q : quo_q;
	assign abs_a    = rd_a_q[BW-1] ? -rd_a_q : rd_a_q;
	assign abs_b    = rd_b_q[BW-1] ? -rd_b_q : rd_b_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_q;
		wr_data = mul_next;
		case (ph_q)
			plsf_pkg::PH_IDLE: begin
				if (cmd.start && cmd.op == plsf_pkg::OP_LD) begin
					wr_en   = 1'b1;
					wr_addr = cmd.rd;
					wr_data = ld_val;
				end else if (cmd.start && cmd.op == plsf_pkg::OP_SUB) begin
					wr_en   = 1'b1;
					wr_addr = cmd.rd;
					wr_data = sub_val;
				end
			end
			plsf_pkg::PH_MUL: begin
				wr_en = (it_q == '1);
			end
			plsf_pkg::PH_DFIN: begin
				wr_en   = 1'b1;
				wr_data = quo_fin;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= plsf_pkg::PH_IDLE;
			done_q <= 1'b0;
			rd_q   <= '0;
			x_q    <= '0;
			y_q    <= '0;
			acc_q  <= '0;
			quo_q  <= '0;
			it_q   <= '0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				plsf_pkg::PH_IDLE: begin
					if (cmd.start) begin
						rd_q <= cmd.rd;
						case (cmd.op)
							plsf_pkg::OP_MUL: begin
								x_q   <= rd_a_q;
								y_q   <= rd_b_q;
								acc_q <= '0;
								it_q  <= '0;
								ph_q  <= plsf_pkg::PH_MUL;
							end
							plsf_pkg::OP_DIV: begin
								neg_q <= rd_a_q[BW-1] ^ rd_b_q[BW-1];
								x_q   <= abs_a;
								y_q   <= abs_b;
								ph_q  <= plsf_pkg::PH_DPREP;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				plsf_pkg::PH_MUL: begin
					acc_q <= mul_next;
					x_q   <= x_q << 1;
					y_q   <= y_q >> 1;
					it_q  <= it_q + 1'b1;
					if (it_q == '1) begin
						ph_q   <= plsf_pkg::PH_IDLE;
						done_q <= 1'b1;
					end
				end
				plsf_pkg::PH_DPREP: begin
					// Rounded division: (2a + b) / (2b) on magnitudes.
					x_q   <= (x_q << 1) + y_q;
					y_q   <= y_q << 1;
					acc_q <= '0;
					quo_q <= '0;
					it_q  <= '0;
					ph_q  <= plsf_pkg::PH_DIV;
				end
				plsf_pkg::PH_DIV: begin
					acc_q <= rem_next;
					quo_q <= {quo_q[BW-2:0], rem_ge};
					x_q   <= x_q << 1;
					it_q  <= it_q + 1'b1;
					if (it_q == '1) begin
						ph_q <= plsf_pkg::PH_DFIN;
					end
				end
				plsf_pkg::PH_DFIN: begin
					ph_q   <= plsf_pkg::PH_IDLE;
					done_q <= 1'b1;
				end
				default: begin
					ph_q <= plsf_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// Result registers, captured as the program writes them.
	logic [31:0] res_a_q, res_b_q, res_c_q;
	logic [23:0] mean_x_q, mean_y_q, mean_z_q;
	logic        d_zero_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (wr_addr)
				plsf_pkg::R_D:  d_zero_q <= (wr_data == '0);
				plsf_pkg::R_A:  res_a_q  <= plsf_pkg::sat32(wr_data);
				plsf_pkg::R_B:  res_b_q  <= plsf_pkg::sat32(wr_data);
				plsf_pkg::R_C:  res_c_q  <= plsf_pkg::sat32(wr_data);
				plsf_pkg::R_MX: mean_x_q <= plsf_pkg::sat24(wr_data);
				plsf_pkg::R_MY: mean_y_q <= plsf_pkg::sat24(wr_data);
				plsf_pkg::R_MZ: mean_z_q <= plsf_pkg::sat24(wr_data);
				default: begin
				end
			endcase
		end
	end

	logic n_zero;
	assign n_zero = (count_q == '0);

	always_comb begin
		fit.slope_a  = d_zero_q ? '0 : res_a_q;
		fit.slope_b  = d_zero_q ? '0 : res_b_q;
		fit.offset_c = d_zero_q ? '0 : res_c_q;
		fit.mean_x   = n_zero ? '0 : mean_x_q;
		fit.mean_y   = n_zero ? '0 : mean_y_q;
		fit.mean_z   = n_zero ? '0 : mean_z_q;
		if (d_zero_q) begin
			fit.fit_status = plsf_pkg::FS_DEGENERATE;
		end else if (cap_q) begin
			fit.fit_status = plsf_pkg::FS_CAPACITY;
		end else begin
			fit.fit_status = plsf_pkg::FS_OK;
		end
	end

	assign status.pipe_busy = v_s1 | v_s2;
	assign status.done      = done_q;

endmodule

// File: src/plsf_ctrl.sv
// Controller of the plane fit: takes points, then steps the datapath through
// the fit program and presents the result. Depends on plsf_pkg.
module plsf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pt_valid,
	input  logic                 pt_last,
	output logic                 pt_stall,
	input  plsf_pkg::dp_status_t status,
	output plsf_pkg::cmd_t       cmd,
	output logic                 fit_valid,
	input  logic                 fit_stall
);

	plsf_pkg::state_t          state_q, state_d;
	logic [plsf_pkg::PC_W-1:0] pc_q;
	logic                      pc_clr, pc_inc;
	plsf_pkg::instr_t          instr;

	assign instr = plsf_pkg::PROG[pc_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plsf_pkg::ST_ACCUM;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (pc_clr) begin
				pc_q <= '0;
			end else if (pc_inc) begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		pc_clr    = 1'b0;
		pc_inc    = 1'b0;
		cmd.push  = 1'b0;
		cmd.rd_en = 1'b0;
		cmd.start = 1'b0;
		cmd.clear = 1'b0;
		cmd.op    = instr.op;
		cmd.rd    = instr.rd;
		cmd.ra    = instr.ra;
		cmd.rb    = instr.rb;
		pt_stall  = (state_q != plsf_pkg::ST_ACCUM);
		fit_valid = (state_q == plsf_pkg::ST_OUT);
		case (state_q)
			plsf_pkg::ST_ACCUM: begin
				cmd.push = pt_valid;
				if (pt_valid && pt_last) begin
					state_d = plsf_pkg::ST_DRAIN;
				end
			end
			plsf_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) begin
					pc_clr  = 1'b1;
					state_d = plsf_pkg::ST_READ;
				end
			end
			plsf_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = plsf_pkg::ST_EXEC;
			end
			plsf_pkg::ST_EXEC: begin
				cmd.start = 1'b1;
				state_d   = plsf_pkg::ST_WAIT;
			end
			plsf_pkg::ST_WAIT: begin
				if (status.done) begin
					if (pc_q == plsf_pkg::PC_W'(plsf_pkg::PROG_LEN - 1)) begin
						state_d = plsf_pkg::ST_OUT;
					end else begin
						pc_inc  = 1'b1;
						state_d = plsf_pkg::ST_READ;
					end
				end
			end
			plsf_pkg::ST_OUT: begin
				if (!fit_stall) begin
					cmd.clear = 1'b1;
					state_d   = plsf_pkg::ST_ACCUM;
				end
			end
			default: begin
				state_d = plsf_pkg::ST_ACCUM;
			end
		endcase
	end

endmodule
